>>> rtl/sha1_pkg.sv
// Shared types and constants for the SHA-1 block hash unit.
package sha1_pkg;

    localparam int unsigned BLOCK_WORDS  = 16;
    localparam int unsigned ROUNDS       = 80;
    localparam int unsigned DIGEST_WORDS = 5;
    localparam int unsigned ROUND_W      = $clog2(ROUNDS);
    localparam int unsigned COUNT_W      = $clog2(BLOCK_WORDS);
    localparam int unsigned DCNT_W       = $clog2(DIGEST_WORDS + 1);

    localparam logic [31:0] IV_WORDS [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

    typedef enum logic [1:0] {
        S_LOAD,
        S_ROUND,
        S_ADD
    } t_state;

    // Round group: selects the boolean function and the round constant.
    typedef enum logic [1:0] {
        P_CH,
        P_PARITY1,
        P_MAJ,
        P_PARITY2
    } t_phase;

    typedef struct packed {
        logic   shift_word;
        logic   reload_iv;
        logic   init_vars;
        logic   round;
        t_phase phase;
        logic   add_chain;
        logic   load_out;
    } t_dp_cmd;

endpackage

>>> rtl/sha1_stream_if.sv
// Valid/ready channel interfaces for message words and digest words.
interface sha1_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic        new_message;
    logic        final_block;

    modport source (output valid, output msg_word, output new_message,
                    output final_block, input ready);
    modport sink   (input valid, input msg_word, input new_message,
                    input final_block, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    modport source (output valid, output digest_word, output digest_index,
                    output digest_last, input ready);
    modport sink   (input valid, input digest_word, input digest_index,
                    input digest_last, output ready);
endinterface

>>> rtl/sha1_ctrl.sv
// Controller: word counting, round sequencing and digest hand-off.
module sha1_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_new_message,
    input  logic              i_final_block,
    input  logic              i_out_busy,
    output logic              o_in_ready,
    output sha1_pkg::t_dp_cmd o_cmd
);
    import sha1_pkg::*;

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_word_cnt, n_word_cnt;
    logic [ROUND_W-1:0]   r_round, n_round;
    logic                 r_final, n_final;
    logic                 w_accept;
    logic                 w_block_done;
    logic                 w_add_ok;

    localparam logic [COUNT_W-1:0] LAST_SLOT  = COUNT_W'(BLOCK_WORDS - 1);
    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);

    assign w_accept     = i_in_valid && (r_state == S_LOAD);
    assign w_block_done = w_accept && !i_new_message && (r_word_cnt == LAST_SLOT);
    // Hold the final add until the digest buffer has drained.
    assign w_add_ok     = !r_final || !i_out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_word_cnt <= '0;
            r_round    <= '0;
            r_final    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_word_cnt <= n_word_cnt;
            r_round    <= n_round;
            r_final    <= n_final;
        end
    end

    // Next state
    always_comb begin
        n_state    = r_state;
        n_word_cnt = r_word_cnt;
        n_round    = r_round;
        n_final    = r_final;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (i_new_message) begin
                        n_word_cnt = COUNT_W'(1);
                    end else begin
                        n_word_cnt = r_word_cnt + COUNT_W'(1);
                    end
                end
                if (w_block_done) begin
                    n_state = S_ROUND;
                    n_round = '0;
                    n_final = i_final_block;
                end
            end
            S_ROUND: begin
                n_round = r_round + ROUND_W'(1);
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (w_add_ok) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = (r_state == S_LOAD);
        o_cmd      = '0;
        o_cmd.shift_word = w_accept;
        o_cmd.reload_iv  = w_accept && i_new_message;
        o_cmd.init_vars  = w_block_done;
        o_cmd.round      = (r_state == S_ROUND);
        priority if (r_round < ROUND_W'(20)) begin
            o_cmd.phase = P_CH;
        end else if (r_round < ROUND_W'(40)) begin
            o_cmd.phase = P_PARITY1;
        end else if (r_round < ROUND_W'(60)) begin
            o_cmd.phase = P_MAJ;
        end else begin
            o_cmd.phase = P_PARITY2;
        end
        o_cmd.add_chain = (r_state == S_ADD) && w_add_ok;
        o_cmd.load_out  = (r_state == S_ADD) && r_final && !i_out_busy;
    end

endmodule

>>> rtl/sha1_dp.sv
// Datapath: schedule shift line, round unit, chaining value and digest buffer.
module sha1_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1_pkg::t_dp_cmd i_cmd,
    input  logic [31:0]       i_msg_word,
    input  logic              i_out_ready,
    output logic              o_out_busy,
    output logic              o_out_valid,
    output logic [31:0]       o_digest_word,
    output logic [2:0]        o_digest_index,
    output logic              o_digest_last
);
    import sha1_pkg::*;

    logic [31:0]         r_sched [BLOCK_WORDS];
    logic [31:0]         r_a, r_b, r_c, r_d, r_e;
    logic [31:0]         r_chain [DIGEST_WORDS];
    logic [31:0]         r_out_word [DIGEST_WORDS];
    logic [DCNT_W-1:0]   r_out_cnt;
    logic [2:0]          r_out_idx;

    logic [31:0]         w_expand;
    logic [31:0]         w_mix;
    logic [31:0]         w_f;
    logic [31:0]         w_k;
    logic [31:0]         w_tmp;
    logic [31:0]         w_vars [DIGEST_WORDS];
    logic [31:0]         w_sum  [DIGEST_WORDS];
    logic                w_out_pop;

    // W[t+16] from the window W[t..t+15]
    assign w_mix    = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
    assign w_expand = {w_mix[30:0], w_mix[31]};

    always_comb begin
        unique case (i_cmd.phase)
            P_CH: begin
                w_f = (r_b & r_c) | (~r_b & r_d);
                w_k = K_CH;
            end
            P_PARITY1: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = K_PA1;
            end
            P_MAJ: begin
                w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
                w_k = K_MAJ;
            end
            P_PARITY2: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = K_PA2;
            end
            default: begin
                w_f = r_b ^ r_c ^ r_d;
                w_k = K_PA2;
            end
        endcase
    end

    assign w_tmp = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_sched[0];

    assign w_vars[0] = r_a;
    assign w_vars[1] = r_b;
    assign w_vars[2] = r_c;
    assign w_vars[3] = r_d;
    assign w_vars[4] = r_e;

    always_comb begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
            w_sum[i] = r_chain[i] + w_vars[i];
        end
    end

    assign w_out_pop = o_out_valid && i_out_ready;

    // Schedule line and working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_word || i_cmd.round) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_sched[i] <= r_sched[i+1];
            end
            r_sched[BLOCK_WORDS-1] <= i_cmd.round ? w_expand : i_msg_word;
        end
        if (i_cmd.init_vars) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_cmd.round) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_tmp;
        end
    end

    // Chaining value and digest counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain   <= IV_WORDS;
            r_out_cnt <= '0;
            r_out_idx <= '0;
        end else begin
            if (i_cmd.reload_iv) begin
                r_chain <= IV_WORDS;
            end else if (i_cmd.add_chain) begin
                r_chain <= w_sum;
            end
            if (i_cmd.load_out) begin
                r_out_cnt <= DCNT_W'(DIGEST_WORDS);
                r_out_idx <= '0;
            end else if (w_out_pop) begin
                r_out_cnt <= r_out_cnt - DCNT_W'(1);
                r_out_idx <= r_out_idx + 3'd1;
            end
        end
    end

    // Digest words, head first
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_word <= w_sum;
        end else if (w_out_pop) begin
            for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
                r_out_word[i] <= r_out_word[i+1];
            end
        end
    end

    assign o_out_busy     = (r_out_cnt != '0);
    assign o_out_valid    = (r_out_cnt != '0);
    assign o_digest_word  = r_out_word[0];
    assign o_digest_index = r_out_idx;
    assign o_digest_last  = (r_out_cnt == DCNT_W'(1));

endmodule

>>> rtl/sha1_block_hash_unit.sv
// Top level of the SHA-1 block hash unit.
// A 512-bit block takes 16 word beats, then 80 rounds and one add step on the single
// shared round unit; the next block's words wait until the add step is done. Digest
// words follow the add step of a final block, one beat each. Words are refused during
// rounds and the add step; a new final block waits in the add state until the previous
// digest has drained. Synchronous active-low reset loads the initial value.
module sha1_block_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1_in_if.sink     i_in,
    sha1_out_if.source  o_out
);
    import sha1_pkg::*;

    t_dp_cmd w_cmd;
    logic    w_out_busy;

    sha1_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_new_message (i_in.new_message),
        .i_final_block (i_in.final_block),
        .i_out_busy    (w_out_busy),
        .o_in_ready    (i_in.ready),
        .o_cmd         (w_cmd)
    );

    sha1_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_msg_word     (i_in.msg_word),
        .i_out_ready    (o_out.ready),
        .o_out_busy     (w_out_busy),
        .o_out_valid    (o_out.valid),
        .o_digest_word  (o_out.digest_word),
        .o_digest_index (o_out.digest_index),
        .o_digest_last  (o_out.digest_last)
    );

endmodule

>>> rtl/sha1_checker.sv
// Port-level checks for the SHA-1 block hash unit, bound to the top level.
module sha1_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_digest_word,
    input logic [2:0]  i_digest_index,
    input logic        i_digest_last
);

    // A stalled digest beat keeps its word.
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_digest_word))
        else $error("digest word changed while stalled");

    // Last flag marks exactly the fifth word.
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_digest_last == (i_digest_index == 3'd4)))
        else $error("digest_last does not match index 4");

    // Words of one digest follow back to back in index order.
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_digest_last |=>
            i_out_valid && (i_digest_index == $past(i_digest_index) + 3'd1))
        else $error("digest index did not advance");

    // A digest opens at index zero.
    a_first_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> (i_digest_index == 3'd0))
        else $error("digest did not start at index 0");

    // Input refused right after an accepted word does not become ready again at once.
    a_busy_after_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready ##1 !i_in_ready |=> !i_in_ready)
        else $error("input accepted in the middle of the rounds");

endmodule

bind sha1_block_hash_unit sha1_checker u_sha1_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_digest_word  (o_out.digest_word),
    .i_digest_index (o_out.digest_index),
    .i_digest_last  (o_out.digest_last)
);

>>> tb/tb.sv
// Self-checking bench for the SHA-1 block hash unit: table of known words, then random messages.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        fresh;
        logic        fin;
    } t_msg_beat;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    // known: the digest of this row is typed in below instead of predicted
    typedef struct packed {
        logic [31:0] word;
        logic        fresh;
        logic        fin;
        logic        known;
    } t_dir_row;

    localparam int unsigned DIR_ROWS = 24;
    localparam int unsigned ITEM_GOAL = 410;
    localparam int unsigned HOLD_CYCLES = 1500;
    localparam int unsigned TAIL_CYCLES = 120;

    localparam logic [31:0] ABC_DIGEST [DIGEST_WORDS] = '{
        32'hA9993E36, 32'h4706816A, 32'hBA3E2571, 32'h7850C26C, 32'h9CD0D89D
    };

    // Partial block of all-ones and zero words (dropped by the next new message), the padded
    // "abc" block, then a partial block that continues the chain.
    localparam t_dir_row DIRECTED_ROWS [DIR_ROWS] = '{
        '{32'hFFFFFFFF, 1'b1, 1'b1, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 1'b1, 1'b0},
        '{32'h61626380, 1'b1, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0},
        '{32'h00000018, 1'b0, 1'b1, 1'b1},
        '{32'hFFFFFFFF, 1'b0, 1'b1, 1'b0},
        '{32'h00000000, 1'b0, 1'b0, 1'b0},
        '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0},
        '{32'h00000000, 1'b0, 1'b1, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sha1_in_if  msg_ch ();
    sha1_out_if digest_ch ();

    sha1_block_hash_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (msg_ch),
        .o_out   (digest_ch)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [31:0]  sched_words [BLOCK_WORDS];
    logic [31:0]  chain_words [DIGEST_WORDS];
    int unsigned  block_fill;

    t_digest_beat pending_digest [$];
    int unsigned  err_cnt = 0;
    int unsigned  words_sent = 0;
    bit           tx_calm = 1'b0;
    bit           rx_calm = 1'b0;
    int unsigned  rx_hold = 0;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic void sha1_compress();
        logic [31:0] a, b, c, d, e, f, k, w, tmp;
        int unsigned slot;
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (int unsigned t = 0; t < ROUNDS; t++) begin
            slot = t % BLOCK_WORDS;
            if (t >= BLOCK_WORDS) begin
                w = sched_words[(t - 3) % BLOCK_WORDS] ^ sched_words[(t - 8) % BLOCK_WORDS]
                  ^ sched_words[(t - 14) % BLOCK_WORDS] ^ sched_words[slot];
                sched_words[slot] = rotl32(w, 1);
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_PA1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end else begin
                f = b ^ c ^ d;
                k = K_PA2;
            end
            tmp = rotl32(a, 5) + f + e + k + sched_words[slot];
            e = d;
            d = c;
            c = rotl32(b, 30);
            b = a;
            a = tmp;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endfunction

    // Absorb one message word; return the number of digest beats it produces.
    function automatic int unsigned sha1_absorb_word(input t_msg_beat beat,
                                                     output t_digest_beat dig [DIGEST_WORDS]);
        if (beat.fresh) begin
            for (int i = 0; i < DIGEST_WORDS; i++)
                chain_words[i] = IV_WORDS[i];
            block_fill = 0;
        end
        sched_words[block_fill] = beat.word;
        if (block_fill != BLOCK_WORDS - 1) begin
            block_fill++;
            return 0;
        end
        block_fill = 0;
        sha1_compress();
        if (!beat.fin)
            return 0;
        for (int i = 0; i < DIGEST_WORDS; i++)
            dig[i] = '{chain_words[i], 3'(i), (i == DIGEST_WORDS - 1)};
        return DIGEST_WORDS;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
        err_cnt++;
    endtask

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'h00000000;
        if (r == 1)
            return 32'hFFFFFFFF;
        return $urandom;
    endfunction

    task automatic idle_before_beat();
        int unsigned n;
        n = 0;
        if (!tx_calm)
            while (n < 20 && $urandom_range(99) < 30)
                n++;
        if (n > 0) begin
            msg_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_word(input t_msg_beat beat, input bit known);
        t_digest_beat dig [DIGEST_WORDS];
        int unsigned  n;
        idle_before_beat();
        msg_ch.valid       <= 1'b1;
        msg_ch.msg_word    <= beat.word;
        msg_ch.new_message <= beat.fresh;
        msg_ch.final_block <= beat.fin;
        do @(posedge i_clk); while (!msg_ch.ready);
        n = sha1_absorb_word(beat, dig);
        for (int unsigned i = 0; i < n; i++) begin
            if (known)
                dig[i].word = ABC_DIGEST[i];
            pending_digest.push_back(dig[i]);
        end
        words_sent++;
    endtask

    // resume: continue the current chain instead of starting a new message
    task automatic send_message(input int unsigned nblocks, input bit resume);
        t_msg_beat beat;
        for (int unsigned blk = 0; blk < nblocks; blk++) begin
            for (int unsigned w = 0; w < BLOCK_WORDS; w++) begin
                beat.word  = pick_word();
                beat.fresh = (blk == 0 && w == 0 && !resume);
                if (w == BLOCK_WORDS - 1)
                    beat.fin = (blk == nblocks - 1);
                else
                    beat.fin = 1'($urandom_range(1));
                send_word(beat, 1'b0);
            end
        end
    endtask

    // Partial block with random flags; a later new message drops it, a resumed one builds on it.
    task automatic send_fragment();
        t_msg_beat   beat;
        int unsigned len;
        len = $urandom_range(1, BLOCK_WORDS - 1);
        for (int unsigned w = 0; w < len; w++) begin
            beat.word  = pick_word();
            beat.fresh = (w == 0) ? 1'b1 : 1'($urandom_range(3) == 0);
            beat.fin   = 1'($urandom_range(1));
            send_word(beat, 1'b0);
        end
    endtask

    function automatic int unsigned pick_blocks();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 1;
        if (r < 85)
            return 2;
        return 3;
    endfunction

    task automatic random_traffic(input int unsigned goal);
        int unsigned r;
        while (words_sent < goal) begin
            r = $urandom_range(99);
            if (r < 70)
                send_message(pick_blocks(), 1'b0);
            else if (r < 82)
                send_message(1, 1'b1);
            else
                send_fragment();
        end
    endtask

    task automatic wait_drained();
        msg_ch.valid <= 1'b0;
        while (pending_digest.size() != 0)
            @(posedge i_clk);
    endtask

    // receiver: random stalls, a calm mode, and a long counted hold-off
    initial begin
        digest_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                digest_ch.ready <= 1'b0;
                repeat (rx_hold) @(posedge i_clk);
                rx_hold = 0;
            end else begin
                digest_ch.ready <= rx_calm || ($urandom_range(99) >= 30);
            end
        end
    end

    always @(posedge i_clk) begin : digest_monitor
        t_digest_beat want;
        if (i_rst_n && digest_ch.valid && digest_ch.ready) begin
            if (pending_digest.size() == 0) begin
                report_mismatch("unexpected digest beat", digest_ch.digest_word, 32'h0);
            end else begin
                want = pending_digest.pop_front();
                if (digest_ch.digest_word !== want.word)
                    report_mismatch("digest_word", digest_ch.digest_word, want.word);
                if (digest_ch.digest_index !== want.index)
                    report_mismatch("digest_index", 32'(digest_ch.digest_index),
                                    32'(want.index));
                if (digest_ch.digest_last !== want.last)
                    report_mismatch("digest_last", 32'(digest_ch.digest_last),
                                    32'(want.last));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        t_msg_beat beat;
        i_rst_n            <= 1'b0;
        msg_ch.valid       <= 1'b0;
        msg_ch.msg_word    <= 32'h0;
        msg_ch.new_message <= 1'b0;
        msg_ch.final_block <= 1'b0;
        for (int i = 0; i < BLOCK_WORDS; i++)
            sched_words[i] = 32'h0;
        for (int i = 0; i < DIGEST_WORDS; i++)
            chain_words[i] = IV_WORDS[i];
        block_fill = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int unsigned i = 0; i < DIR_ROWS; i++) begin
            beat = '{DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].fresh, DIRECTED_ROWS[i].fin};
            send_word(beat, DIRECTED_ROWS[i].known);
        end

        random_traffic(words_sent + 150);

        // hold the digest side while final blocks keep coming, then drain
        tx_calm = 1'b1;
        rx_hold = HOLD_CYCLES;
        repeat (4) send_message(1, 1'b0);
        tx_calm = 1'b0;
        wait_drained();

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        repeat (3) send_message(pick_blocks(), 1'b0);
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        random_traffic(ITEM_GOAL);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> sha1_block_hash_unit.f
rtl/sha1_pkg.sv
rtl/sha1_stream_if.sv
rtl/sha1_ctrl.sv
rtl/sha1_dp.sv
rtl/sha1_block_hash_unit.sv
rtl/sha1_checker.sv
tb/tb.sv
